@@ hdl/tccm_pkg.sv @@
// ----------------------------------------------------------------------------
// tccm_pkg
// shared types and constants of the top-three class colour mixer
// ----------------------------------------------------------------------------
package tccm_pkg;

    localparam int NUM_CLASSES_DEF = 8;
    localparam int PROB_BITS_DEF   = 16;
    localparam int IN_BITS         = 16;
    localparam int CFG_IDX_W       = 3;
    localparam int CFG_DATA_W      = 48;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_MIX_MODE  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COLORS_01 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_COLORS_23 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_COLORS_45 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_COLORS_67 = 3'd4;

    // mix modes
    localparam logic [1:0] MODE_WEIGHTED = 2'd0;
    localparam logic [1:0] MODE_CENTROID = 2'd1;
    localparam logic [1:0] MODE_TOP      = 2'd2;

    // reset contents of the colour table
    localparam logic [CFG_DATA_W-1:0] COLORS_01_RST = 48'd280710539575296;
    localparam logic [CFG_DATA_W-1:0] COLORS_23_RST = 48'd266885065081022;
    localparam logic [CFG_DATA_W-1:0] COLORS_45_RST = 48'd3304453621;
    localparam logic [CFG_DATA_W-1:0] COLORS_67_RST = 48'd56073157518076;

    typedef struct packed {
        logic [IN_BITS-1:0] prob_0;
        logic [IN_BITS-1:0] prob_1;
        logic [IN_BITS-1:0] prob_2;
        logic [IN_BITS-1:0] prob_3;
        logic [IN_BITS-1:0] prob_4;
        logic [IN_BITS-1:0] prob_5;
        logic [IN_BITS-1:0] prob_6;
        logic [IN_BITS-1:0] prob_7;
    } prob_item_t;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [2:0] first_class;
        logic [2:0] second_class;
        logic [2:0] third_class;
        logic       below_floor;
    } color_item_t;

endpackage

@@ hdl/tccm_rank.sv @@
// ----------------------------------------------------------------------------
// tccm_rank
// picks the three largest probabilities, lower index first on ties
// ----------------------------------------------------------------------------
module tccm_rank
    import tccm_pkg::*;
#(
    parameter int NUM_CLASSES = NUM_CLASSES_DEF,
    parameter int PROB_BITS   = PROB_BITS_DEF
)
(
    input  logic [7:0][PROB_BITS-1:0] prob,
    output logic [2:0][2:0]           idx
);

    logic [2:0] cnt [8];

    // each class counts the classes that outrank it, giving a unique rank
    always_comb
    begin
        for (int i = 0; i < 8; i++)
        begin
            cnt[i] = 3'd0;
            for (int j = 0; j < NUM_CLASSES; j++)
            begin
                if ((j < i && prob[j] >= prob[i]) || (j > i && prob[j] > prob[i]))
                begin
                    cnt[i] = cnt[i] + 3'd1;
                end
            end
        end
        idx = '0;
        for (int r = 0; r < 3; r++)
        begin
            for (int i = 0; i < NUM_CLASSES; i++)
            begin
                if (cnt[i] == 3'(r))
                begin
                    idx[r] = idx[r] | 3'(i);
                end
            end
        end
    end

endmodule

@@ hdl/top_three_class_color_mixer.sv @@
// ----------------------------------------------------------------------------
// top_three_class_color_mixer
// ranks eight class probabilities and mixes the colours of the top three
// ----------------------------------------------------------------------------
// A fully pipelined mixer: one item may enter every cycle while the output
// is not stalled. Most of the pipe is the restoring divider of the weighted
// mode, which resolves one quotient bit per stage over eight stages for all
// three colour channels at once. A stall on the output freezes only the
// stages that are full, so empty stages keep filling until the whole pipe
// is occupied. Configuration writes are always taken (cfg_ready is tied
// high) and must only be made while the pipe is empty.
module top_three_class_color_mixer
    import tccm_pkg::*;
#(
    parameter int NUM_CLASSES = NUM_CLASSES_DEF,
    parameter int PROB_BITS   = PROB_BITS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  prob_valid,
    output logic                  prob_stall,
    input  prob_item_t            prob_item,
    output logic                  color_valid,
    input  logic                  color_stall,
    output color_item_t           color_item,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int SQW       = 2 * PROB_BITS;
    localparam int SUMW      = SQW + 2;
    localparam int PRODW     = SQW + 8;
    localparam int ACCW      = SQW + 10;
    localparam int DIV_STEPS = 8;
    localparam int NS        = 5 + DIV_STEPS;
    localparam longint unsigned PROB_MAX = (64'd1 << PROB_BITS) - 64'd1;
    localparam longint unsigned SQ_FLOOR = (64'd1 << SQW) / 1000;

    typedef struct packed {
        logic [2:0][ACCW-1:0] rem;
        logic [2:0][7:0]      quo;
        logic [SUMW-1:0]      sum;
        logic                 below;
        logic [2:0][7:0]      cen;
        logic [23:0]          top;
        logic [2:0][2:0]      idx;
    } div_t;

    // configuration
    logic [1:0]            mix_mode_reg;
    logic [CFG_DATA_W-1:0] colors_reg [4];
    logic [23:0]           color_tab [8];

    // pipeline valid bits and advance chain
    logic [NS-1:0] v_reg;
    logic [NS-1:0] adv;

    // stage 0: saturated probabilities
    logic [7:0][PROB_BITS-1:0] p0_next;
    logic [7:0][PROB_BITS-1:0] p0_reg;
    logic [IN_BITS-1:0]        raw [8];

    // stage 1: ranking
    logic [2:0][2:0]           idx1_next;
    logic [2:0][2:0]           idx1_reg;
    logic [2:0][PROB_BITS-1:0] pr1_reg;
    logic [2:0][23:0]          col1_reg;

    // stage 2: squares and centroid sums
    logic [2:0][SQW-1:0]       sq2_reg;
    logic [2:0][9:0]           csum2_reg;
    logic [2:0][23:0]          col2_reg;
    logic [2:0][2:0]           idx2_reg;

    // stage 3: weighted products, square sum, centroid
    logic [2:0][2:0][PRODW-1:0] prod3_reg;
    logic [SUMW-1:0]            sum3_reg;
    logic [2:0][7:0]            cen3_reg;
    logic [23:0]                top3_reg;
    logic [2:0][2:0]            idx3_reg;

    // stage 4 and divider stages
    div_t dv_reg  [DIV_STEPS+1];
    div_t dv_next [DIV_STEPS+1];

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mix_mode_reg  <= MODE_WEIGHTED;
            colors_reg[0] <= COLORS_01_RST;
            colors_reg[1] <= COLORS_23_RST;
            colors_reg[2] <= COLORS_45_RST;
            colors_reg[3] <= COLORS_67_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_MIX_MODE:  mix_mode_reg  <= cfg_data[1:0];
                REG_COLORS_01: colors_reg[0] <= cfg_data;
                REG_COLORS_23: colors_reg[1] <= cfg_data;
                REG_COLORS_45: colors_reg[2] <= cfg_data;
                REG_COLORS_67: colors_reg[3] <= cfg_data;
                default:       ;
            endcase
        end
    end

    // lower class of a pair in the low half
    always_comb
    begin
        for (int k = 0; k < 8; k++)
        begin
            color_tab[k] = colors_reg[k / 2][24 * (k % 2) +: 24];
        end
    end

    // a stage moves on when it is empty or its successor moves on
    always_comb
    begin
        adv[NS-1] = !v_reg[NS-1] || !color_stall;
        for (int i = NS - 2; i >= 0; i--)
        begin
            adv[i] = !v_reg[i] || adv[i+1];
        end
    end

    assign prob_stall = !adv[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            if (adv[0])
            begin
                v_reg[0] <= prob_valid;
            end
            for (int i = 1; i < NS; i++)
            begin
                if (adv[i])
                begin
                    v_reg[i] <= v_reg[i-1];
                end
            end
        end
    end

    // saturation to the largest Q0.PROB_BITS value
    assign raw[0] = prob_item.prob_0;
    assign raw[1] = prob_item.prob_1;
    assign raw[2] = prob_item.prob_2;
    assign raw[3] = prob_item.prob_3;
    assign raw[4] = prob_item.prob_4;
    assign raw[5] = prob_item.prob_5;
    assign raw[6] = prob_item.prob_6;
    assign raw[7] = prob_item.prob_7;

    always_comb
    begin
        for (int i = 0; i < 8; i++)
        begin
            if (64'(raw[i]) > PROB_MAX)
            begin
                p0_next[i] = PROB_BITS'(PROB_MAX);
            end
            else
            begin
                p0_next[i] = PROB_BITS'(raw[i]);
            end
        end
    end

    tccm_rank #(
        .NUM_CLASSES (NUM_CLASSES),
        .PROB_BITS   (PROB_BITS)
    ) u_rank (
        .prob (p0_reg),
        .idx  (idx1_next)
    );

    // stage 4 and the divider steps
    always_comb
    begin
        logic [ACCW-1:0] trial;
        dv_next[0].sum   = sum3_reg;
        dv_next[0].below = 64'(sum3_reg) <= SQ_FLOOR;
        dv_next[0].cen   = cen3_reg;
        dv_next[0].top   = top3_reg;
        dv_next[0].idx   = idx3_reg;
        dv_next[0].quo   = '0;
        for (int c = 0; c < 3; c++)
        begin
            dv_next[0].rem[c] = ACCW'(prod3_reg[c][0]) + ACCW'(prod3_reg[c][1])
                              + ACCW'(prod3_reg[c][2]);
        end
        // restoring division, one quotient bit per stage, msb first
        for (int d = 1; d <= DIV_STEPS; d++)
        begin
            dv_next[d] = dv_reg[d-1];
            trial = ACCW'(dv_reg[d-1].sum) << (DIV_STEPS - d);
            for (int c = 0; c < 3; c++)
            begin
                if (dv_reg[d-1].rem[c] >= trial)
                begin
                    dv_next[d].rem[c]              = dv_reg[d-1].rem[c] - trial;
                    dv_next[d].quo[c][DIV_STEPS-d] = 1'b1;
                end
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (adv[0])
        begin
            p0_reg <= p0_next;
        end
        if (adv[1])
        begin
            idx1_reg <= idx1_next;
            for (int r = 0; r < 3; r++)
            begin
                pr1_reg[r]  <= p0_reg[idx1_next[r]];
                col1_reg[r] <= color_tab[idx1_next[r]];
            end
        end
        if (adv[2])
        begin
            idx2_reg <= idx1_reg;
            col2_reg <= col1_reg;
            for (int r = 0; r < 3; r++)
            begin
                sq2_reg[r] <= SQW'(pr1_reg[r]) * SQW'(pr1_reg[r]);
            end
            for (int c = 0; c < 3; c++)
            begin
                csum2_reg[c] <= 10'(col1_reg[0][23-8*c -: 8]) + 10'(col1_reg[1][23-8*c -: 8])
                              + 10'(col1_reg[2][23-8*c -: 8]);
            end
        end
        if (adv[3])
        begin
            idx3_reg <= idx2_reg;
            top3_reg <= col2_reg[0];
            sum3_reg <= SUMW'(sq2_reg[0]) + SUMW'(sq2_reg[1]) + SUMW'(sq2_reg[2]);
            for (int c = 0; c < 3; c++)
            begin
                // divide by three as a reciprocal multiply, exact below 1536
                cen3_reg[c] <= 8'((20'(csum2_reg[c]) * 20'd683) >> 11);
                for (int r = 0; r < 3; r++)
                begin
                    prod3_reg[c][r] <= PRODW'(col2_reg[r][23-8*c -: 8]) * PRODW'(sq2_reg[r]);
                end
            end
        end
        for (int d = 0; d <= DIV_STEPS; d++)
        begin
            if (adv[4+d])
            begin
                dv_reg[d] <= dv_next[d];
            end
        end
    end

    // result assembly from the last stage
    assign color_valid = v_reg[NS-1];

    always_comb
    begin
        color_item.first_class  = dv_reg[DIV_STEPS].idx[0];
        color_item.second_class = dv_reg[DIV_STEPS].idx[1];
        color_item.third_class  = dv_reg[DIV_STEPS].idx[2];
        color_item.below_floor  = 1'b0;
        color_item.red          = 8'd0;
        color_item.green        = 8'd0;
        color_item.blue         = 8'd0;
        case (mix_mode_reg)
            MODE_WEIGHTED:
            begin
                color_item.below_floor = dv_reg[DIV_STEPS].below;
                if (!dv_reg[DIV_STEPS].below)
                begin
                    color_item.red   = dv_reg[DIV_STEPS].quo[0];
                    color_item.green = dv_reg[DIV_STEPS].quo[1];
                    color_item.blue  = dv_reg[DIV_STEPS].quo[2];
                end
            end
            MODE_CENTROID:
            begin
                color_item.red   = dv_reg[DIV_STEPS].cen[0];
                color_item.green = dv_reg[DIV_STEPS].cen[1];
                color_item.blue  = dv_reg[DIV_STEPS].cen[2];
            end
            MODE_TOP:
            begin
                color_item.red   = dv_reg[DIV_STEPS].top[23:16];
                color_item.green = dv_reg[DIV_STEPS].top[15:8];
                color_item.blue  = dv_reg[DIV_STEPS].top[7:0];
            end
            default: ;
        endcase
    end

endmodule

@@ hdl/tccm_checker.sv @@
// ----------------------------------------------------------------------------
// tccm_checker
// port-level checks of the colour mixer, bound to the top level
// ----------------------------------------------------------------------------
module tccm_checker
    import tccm_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        color_valid,
    input logic        color_stall,
    input color_item_t color_item
);

    // a stalled result stays offered
    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        color_valid && color_stall |=> color_valid)
        else $error("result withdrawn while stalled");

    // a stalled result keeps its payload
    a_hold_item: assert property (@(posedge clk) disable iff (!rst_n)
        color_valid && color_stall |=> $stable(color_item))
        else $error("result changed while stalled");

    // floor flag always comes with black
    a_floor_black: assert property (@(posedge clk) disable iff (!rst_n)
        color_valid && color_item.below_floor |->
            color_item.red == 8'd0 && color_item.green == 8'd0 && color_item.blue == 8'd0)
        else $error("below floor but colour not black");

    // the three ranked classes are distinct
    a_distinct: assert property (@(posedge clk) disable iff (!rst_n)
        color_valid |-> color_item.first_class != color_item.second_class
            && color_item.first_class != color_item.third_class
            && color_item.second_class != color_item.third_class)
        else $error("ranked classes repeat");

endmodule

bind top_three_class_color_mixer tccm_checker u_tccm_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .color_valid (color_valid),
    .color_stall (color_stall),
    .color_item  (color_item)
);
